### hw/rtl/mie_pkg.sv
// ----------------------------------------------------------------------------
// mie_pkg: shared constants for the modular inverse block
// Holds the default word width and the fixed widths of the stream fields.
// ----------------------------------------------------------------------------
package mie_pkg;

	// Default width of the internal Euclid arithmetic.
	localparam int unsigned WordWidthDef = 32;

	// Fixed widths of the stream fields.
	localparam int unsigned FieldWidth = 32;
	localparam int unsigned InDataWidth = 2 * FieldWidth;

endpackage

### hw/rtl/mie_divmac.sv
// ----------------------------------------------------------------------------
// mie_divmac: serial divide with folded multiply-accumulate
// Restoring division, one quotient bit per cycle. Each quotient bit, MSB
// first, also drives a Horner accumulation of quotient times cofactor, so
// one step yields the remainder and base + quotient * cofactor.
// ----------------------------------------------------------------------------
module mie_divmac #(
	parameter int unsigned WORD_WIDTH = mie_pkg::WordWidthDef
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [WORD_WIDTH-1:0] dividend,
	input  logic [WORD_WIDTH-1:0] divisor,
	input  logic [WORD_WIDTH-1:0] cof_mul,
	input  logic [WORD_WIDTH-1:0] cof_base,
	output logic                  busy,
	output logic                  done,
	output logic [WORD_WIDTH-1:0] rem,
	output logic [WORD_WIDTH-1:0] cof_out
);

	localparam int unsigned W  = WORD_WIDTH;
	localparam int unsigned CW = $clog2(W);

	logic [W-1:0]  part_q;
	logic [W-1:0]  dvd_q;
	logic [W-1:0]  dsr_q;
	logic [W-1:0]  mul_q;
	logic [W-1:0]  base_q;
	logic [W-1:0]  acc_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [W:0]    part_sh;
	logic [W:0]    part_sub;
	logic          q_bit;
	logic [W-1:0]  acc_nxt;

	// Bring in the next dividend bit and try the subtraction.
	assign part_sh  = {part_q, dvd_q[W-1]};
	assign part_sub = part_sh - {1'b0, dsr_q};
	assign q_bit    = (part_sh >= {1'b0, dsr_q});
	assign acc_nxt  = {acc_q[W-2:0], 1'b0} + (q_bit ? mul_q : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			part_q <= '0;
			dvd_q  <= dividend;
			dsr_q  <= divisor;
			mul_q  <= cof_mul;
			base_q <= cof_base;
			acc_q  <= '0;
		end else if (busy_q) begin
			part_q <= q_bit ? part_sub[W-1:0] : part_sh[W-1:0];
			dvd_q  <= {dvd_q[W-2:0], 1'b0};
			acc_q  <= acc_nxt;
		end
	end

	assign busy    = busy_q;
	assign done    = done_q;
	assign rem     = part_q;
	assign cof_out = base_q + acc_q;

endmodule

### hw/rtl/modular_inverse_ext_euclid.sv
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid: modular inverse by extended Euclid
// Returns the inverse of a value modulo a modulus, tracking one cofactor
// and the parity of the step count, with a flag that tells whether an inverse exists.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Word contents (lowest bits first)
//  ---------+-----------+----------------------------------------------
//  s_axis   | in        | tdata: modulus[31:0], value[63:32]
//  m_axis   | out       | tdata: inverse[31:0]; tuser: has_inverse
//
// The time per word grows with the number of Euclid division steps (at most
// 46 for 32-bit operands); each step runs the serial divider, one quotient
// bit a cycle. s_axis_tready is high only while the sequencer is idle. A
// finished result waits in the output register, so the next word may be
// taken while it stalls; that word then finishes only once the register
// has been emptied. Reset clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid #(
	parameter int unsigned WORD_WIDTH = mie_pkg::WordWidthDef
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [mie_pkg::InDataWidth-1:0]  s_axis_tdata,  // modulus, value
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [mie_pkg::FieldWidth-1:0]   m_axis_tdata,  // inverse
	output logic                             m_axis_tuser   // has_inverse
);

	localparam int unsigned W  = WORD_WIDTH;
	localparam int unsigned FW = mie_pkg::FieldWidth;

	// Sequencer states.
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_CHECK  = 2'd1;
	localparam logic [1:0] ST_DIV    = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]    state_q;
	logic [W-1:0]  mod_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  nrem_q;
	logic [W-1:0]  cof_q;
	logic [W-1:0]  ncof_q;
	logic          odd_q;

	logic          out_valid_q;
	logic [FW-1:0] out_inv_q;
	logic          out_flag_q;

	logic          in_fire;
	logic          out_free;
	logic          out_load;
	logic          div_start;
	logic          div_busy;
	logic          div_done;
	logic [W-1:0]  div_rem;
	logic [W-1:0]  div_cof;
	logic [W-1:0]  result;
	logic          found;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	// The finished word moves into the output register once it is free.
	assign out_load      = (state_q == ST_FINISH) && out_free;

	// A division step is launched from the loop test whenever the running remainder is non-zero.
	assign div_start = (state_q == ST_CHECK) && (nrem_q != '0);

	// The gcd sits in rem_q once the loop ends; an odd step count means the
	// cofactor carries the wrong sign and is folded back through the modulus.
	assign found  = (rem_q == W'(1));
	assign result = !found ? '0 : (odd_q ? (mod_q - cof_q) : cof_q);

	mie_divmac #(
		.WORD_WIDTH (W)
	) u_divmac (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rem_q),
		.divisor  (nrem_q),
		.cof_mul  (ncof_q),
		.cof_base (cof_q),
		.busy     (div_busy),
		.done     (div_done),
		.rem      (div_rem),
		.cof_out  (div_cof)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !m_axis_tready);
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= (nrem_q == '0) ? ST_FINISH : ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_CHECK;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Euclid working registers and the output payload.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mod_q  <= W'(s_axis_tdata[FW-1:0]);
			rem_q  <= W'(s_axis_tdata[2*FW-1:FW]);
			nrem_q <= W'(s_axis_tdata[FW-1:0]);
			cof_q  <= W'(1);
			ncof_q <= '0;
			odd_q  <= 1'b0;
		end else if ((state_q == ST_DIV) && div_done) begin
			cof_q  <= ncof_q;
			ncof_q <= div_cof;
			rem_q  <= nrem_q;
			nrem_q <= div_rem;
			odd_q  <= !odd_q;
		end
		if (out_load) begin
			out_inv_q  <= FW'(result);
			out_flag_q <= found;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_inv_q;
	assign m_axis_tuser  = out_flag_q;

	// The divider only runs on behalf of a word in flight.
	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!div_busy && !div_done))
		else $error("divider active while sequencer idle");

	// A finished division is only reported while the sequencer waits for it.
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("division finished outside the divide state");

	// No inverse is always reported as a zero word.
	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("non-zero inverse reported without a gcd of one");

	// An accepted word always starts with the loop test.
	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_CHECK))
		else $error("accepted word did not enter the loop test");

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for modular_inverse_ext_euclid
// Sends (modulus, value) words, predicts each inverse and its flag with a
// software Euclid loop, and checks every result word in order of arrival.
// ----------------------------------------------------------------------------
module tb;

	localparam int unsigned Width = mie_pkg::FieldWidth;

	// The cycle limit on the whole run leaves a wide margin over the words sent.
	localparam int unsigned CycleLimit = 3000000;
	localparam int unsigned TailCycles = 2000;
	localparam int unsigned LongHoldCycles = 5000;
	localparam int unsigned RandomWords = 340;
	localparam int unsigned PressureWords = 10;
	localparam int unsigned IdlePercent = 15;
	localparam int unsigned PrintedMismatches = 40;

	typedef logic [Width-1:0] word_t;

	// One expected result word, kept with its operands for the report.
	typedef struct {
		word_t modulus;
		word_t value;
		word_t inverse;
		logic  has_inverse;
	} inverse_result_t;

	logic                            clk;
	logic                            arst_n;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	logic [mie_pkg::InDataWidth-1:0] s_axis_tdata;   // modulus[31:0], value[63:32]
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [mie_pkg::FieldWidth-1:0]  m_axis_tdata;   // inverse[31:0]
	logic                            m_axis_tuser;   // has_inverse

	inverse_result_t pending_inverses[$];
	int unsigned     mismatch_count = 0;
	int unsigned     cycle_count = 0;

	// Idling switches for each side, and the request for a long receiver hold.
	logic            tx_gaps = 1'b1;
	logic            rx_gaps = 1'b1;
	int unsigned     hold_asked = 0;
	int unsigned     hold_seen = 0;
	int unsigned     hold_left = 0;

	modular_inverse_ext_euclid uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Extended Euclid with one cofactor and the parity of the step count.
	// All sums and products wrap at the word width, as in the hardware.
	function automatic word_t euclid_inverse(input word_t modulus, input word_t value,
			output logic found);
		word_t cof;
		word_t rem;
		word_t cof_next;
		word_t rem_next;
		word_t quot;
		word_t remd;
		word_t cof_new;
		logic  odd;
		cof = 1;
		rem = value;
		cof_next = 0;
		rem_next = modulus;
		odd = 1'b0;
		while (rem_next != 0) begin
			quot = rem / rem_next;
			remd = rem % rem_next;
			cof_new = cof + quot * cof_next;
			cof = cof_next;
			cof_next = cof_new;
			rem = rem_next;
			rem_next = remd;
			odd = ~odd;
		end
		found = (rem == 1);
		if (!found)
			return '0;
		return odd ? modulus - cof : cof;
	endfunction

	// Consecutive Fibonacci numbers give the longest run of division steps.
	function automatic word_t fibonacci(input int unsigned n);
		word_t a;
		word_t b;
		word_t t;
		a = 0;
		b = 1;
		for (int unsigned i = 0; i < n; i++) begin
			t = a + b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatch_count < PrintedMismatches)
			$display("[%0t] mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	// Offers one word, entered and left at a falling edge. Valid is only
	// lowered when a gap is taken, so it never drops and rises in one step.
	task automatic send_operands(input word_t modulus, input word_t value);
		inverse_result_t exp_word;
		while (tx_gaps && $urandom_range(0, 99) < IdlePercent) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {value, modulus};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		exp_word.modulus = modulus;
		exp_word.value = value;
		exp_word.inverse = euclid_inverse(modulus, value, exp_word.has_inverse);
		pending_inverses.push_back(exp_word);
		@(negedge clk);
	endtask

	// Degenerate moduli and values: zero and one on either side, some with an inverse.
	task automatic test_degenerate_operands();
		send_operands(32'd0, 32'd0);
		send_operands(32'd0, 32'd1);
		send_operands(32'd0, 32'd2);
		send_operands(32'd0, 32'hFFFF_FFFF);
		send_operands(32'd1, 32'd0);
		send_operands(32'd1, 32'd1);
		send_operands(32'd1, 32'hFFFF_FFFF);
		send_operands(32'd2, 32'd0);
		send_operands(32'hFFFF_FFFF, 32'd0);
		send_operands(32'd5, 32'd5);
		send_operands(32'd10, 32'd4);
	endtask

	// Field extremes, both step parities, the longest chain and wrap-around.
	task automatic test_extreme_operands();
		send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFE);
		send_operands(32'hFFFF_FFFE, 32'hFFFF_FFFF);
		send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_operands(32'h8000_0000, 32'hFFFF_FFFF);
		send_operands(32'hFFFF_FFFB, 32'd2);
		send_operands(fibonacci(47), fibonacci(46));
		send_operands(fibonacci(46), fibonacci(47));
		send_operands(32'd7, 32'd3);
		send_operands(32'd11, 32'd3);
		send_operands(32'd13, 32'd100);
		send_operands(32'h5555_5555, 32'hAAAA_AAAA);
	endtask

	// Random operands in a mix of shapes; most are coprime so that the full
	// cofactor path is exercised, some share a factor on purpose.
	task automatic send_random_operands();
		word_t modulus;
		word_t value;
		word_t factor;
		int unsigned n;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				modulus = $urandom;
				value = $urandom;
			end
			3, 4: begin
				case ($urandom_range(0, 3))
					0: modulus = 32'hFFFF_FFFB;
					1: modulus = 32'h7FFF_FFFF;
					2: modulus = 32'd65521;
					default: modulus = $urandom_range(2, 300);
				endcase
				value = $urandom;
			end
			5: begin
				modulus = $urandom_range(0, 20);
				value = $urandom_range(0, 40);
			end
			6: begin
				modulus = $urandom | 32'd1;
				value = $urandom;
			end
			7: begin
				n = $urandom_range(2, 46);
				modulus = fibonacci(n + 1);
				value = fibonacci(n);
				if ($urandom_range(0, 1) == 1) begin
					modulus = fibonacci(n);
					value = fibonacci(n + 1);
				end
			end
			8: begin
				factor = $urandom_range(2, 65535);
				modulus = factor * word_t'($urandom_range(1, 65535));
				value = factor * word_t'($urandom_range(0, 65535));
			end
			default: begin
				modulus = $urandom;
				value = $urandom;
				case ($urandom_range(0, 4))
					0: value = modulus + word_t'($urandom_range(0, 3));
					1: value = modulus - word_t'($urandom_range(1, 3));
					2: value = $urandom_range(0, 1);
					3: modulus = $urandom_range(0, 1);
					default: value = 32'hFFFF_FFFF;
				endcase
			end
		endcase
		send_operands(modulus, value);
	endtask

	// The middle stretch runs with no idling on either side.
	task automatic test_random_operands();
		for (int unsigned i = 0; i < RandomWords; i++) begin
			tx_gaps = !(i >= 120 && i < 200);
			rx_gaps = tx_gaps;
			send_random_operands();
		end
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
	endtask

	// The receiver holds off for a long while; the block keeps one finished
	// word and one more in flight, then has to stall its input.
	task automatic test_output_backpressure();
		hold_asked++;
		for (int unsigned i = 0; i < PressureWords; i++)
			send_random_operands();
	endtask

	// Receiver: random stalls, plus the long hold counted down here.
	always @(negedge clk) begin
		if (hold_seen != hold_asked) begin
			hold_seen = hold_asked;
			hold_left = LongHoldCycles;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !rx_gaps || ($urandom_range(0, 99) >= IdlePercent);
		end
	end

	// Every result word is matched against the oldest prediction.
	always @(posedge clk) begin
		inverse_result_t exp_word;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_inverses.size() == 0) begin
				report_mismatch($sformatf("unexpected word inverse=%h flag=%b",
					m_axis_tdata, m_axis_tuser));
			end else begin
				exp_word = pending_inverses.pop_front();
				if (m_axis_tdata !== exp_word.inverse)
					report_mismatch($sformatf("m=%h v=%h inverse %h, predicted %h",
						exp_word.modulus, exp_word.value, m_axis_tdata, exp_word.inverse));
				if (m_axis_tuser !== exp_word.has_inverse)
					report_mismatch($sformatf("m=%h v=%h flag %b, predicted %b",
						exp_word.modulus, exp_word.value, m_axis_tuser,
						exp_word.has_inverse));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_degenerate_operands();
		test_extreme_operands();
		test_output_backpressure();
		test_random_operands();

		s_axis_tvalid <= 1'b0;
		while (pending_inverses.size() != 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

### modular_inverse_ext_euclid.f
hw/rtl/mie_pkg.sv
hw/rtl/mie_divmac.sv
hw/rtl/modular_inverse_ext_euclid.sv
dv/tb.sv
